// ===== rtl/iprm_pkg.sv =====
// Shared types and constants for the ICMP probe reply matcher.
package iprm_pkg;

  localparam int MAX_PKT_BYTES_DEF = 256;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_IDX_W         = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IP_VERSION    = 3'd0,
    REG_PROBE_KIND    = 3'd1,
    REG_ECHO_ID       = 3'd2,
    REG_PING_SEQ      = 3'd3,
    REG_PING_COOKIE   = 3'd4,
    REG_ECHO_PORT_TAG = 3'd5,
    REG_PROBE_PORT    = 3'd6,
    REG_LOCAL_PORT    = 3'd7
  } cfg_idx_t;

  localparam logic IPV_V4 = 1'b0;
  localparam logic IPV_V6 = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_UDP  = 1'b1;

  // ICMP message types and codes, and the IP protocol number of UDP
  localparam logic [7:0] ICMP4_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP6_PING_REPLY   = 8'd129;
  localparam logic [7:0] ICMP4_DEST_UNREACH = 8'd3;
  localparam logic [7:0] ICMP4_PORT_UNREACH = 8'd3;
  localparam logic [7:0] ICMP6_DEST_UNREACH = 8'd1;
  localparam logic [7:0] ICMP6_PORT_UNREACH = 8'd4;
  localparam logic [7:0] IP_PROTO_UDP       = 8'd17;

  typedef struct packed {
    logic        ip_version;
    logic        probe_kind;
    logic [15:0] echo_id;
    logic [15:0] ping_seq;
    logic [31:0] ping_cookie;
    logic [15:0] echo_port_tag;
    logic [15:0] probe_port;
    logic [15:0] local_port;
  } cfg_t;

  // One byte moving from the input stage into the packet state
  typedef struct packed {
    logic       go;
    logic       last;
    logic [7:0] pkt_byte;
  } step_t;

  // Per-byte outcome of the field compares
  typedef struct packed {
    logic [2:0] hit_cnt;
    logic       miss;
    logic [5:0] icmp_off;
    logic [7:0] inner_off;
  } exam_t;

  typedef struct packed {
    logic is_match;
    logic too_short;
  } res_t;

endpackage

// ===== rtl/iprm_cfg_regs.sv =====
// Configuration register file of the ICMP probe reply matcher.
module iprm_cfg_regs import iprm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_IP_VERSION:    cfg_nxt.ip_version    = cfg_wdata[0];
        REG_PROBE_KIND:    cfg_nxt.probe_kind    = cfg_wdata[0];
        REG_ECHO_ID:       cfg_nxt.echo_id       = cfg_wdata[15:0];
        REG_PING_SEQ:      cfg_nxt.ping_seq      = cfg_wdata[15:0];
        REG_PING_COOKIE:   cfg_nxt.ping_cookie   = cfg_wdata[31:0];
        REG_ECHO_PORT_TAG: cfg_nxt.echo_port_tag = cfg_wdata[15:0];
        REG_PROBE_PORT:    cfg_nxt.probe_port    = cfg_wdata[15:0];
        REG_LOCAL_PORT:    cfg_nxt.local_port    = cfg_wdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/iprm_examine.sv =====
// Per-byte field compares of the ICMP probe reply matcher.
module iprm_examine import iprm_pkg::*; #(
  parameter int MAX_PKT_BYTES = MAX_PKT_BYTES_DEF,
  localparam int PW = $clog2(MAX_PKT_BYTES)
) (
  input  cfg_t          cfg,
  input  logic [PW-1:0] pos,
  input  logic [7:0]    pkt_byte,
  input  logic [5:0]    icmp_off_r,
  input  logic [7:0]    inner_off_r,
  output exam_t         exam
);

  localparam int XW = (PW > 9) ? PW : 9;

  // ICMPv6 port-unreachable layout (fixed positions)
  localparam int V6_NXT_HDR_POS  = 14;
  localparam int V6_SRC_PORT_POS = 48;
  localparam int V6_DST_PORT_POS = 50;

  // Returns {hit, miss} for byte b at p against the big-endian field [base, base+n)
  function automatic logic [1:0] cmp_field(input logic [XW-1:0] p,
                                           input logic [XW-1:0] base,
                                           input logic [2:0]    n,
                                           input logic [31:0]   exp_v,
                                           input logic [7:0]    b);
    logic [XW-1:0] diff;
    logic          in_fld;
    logic [1:0]    k;
    logic [4:0]    sh;
    logic [7:0]    eb;
    diff   = p - base;
    in_fld = (p >= base) && (diff < XW'(n));
    k      = 2'(n - 3'd1 - {1'b0, diff[1:0]});
    sh     = {k, 3'b000};
    eb     = 8'(exp_v >> sh);
    return {in_fld && (eb == b), in_fld && (eb != b)};
  endfunction

  always_comb begin
    logic [XW-1:0] p;
    logic [XW-1:0] off;
    logic [5:0]    icmp_off;
    logic [7:0]    inner;
    logic [1:0]    c0, c1, c2, c3, c4;
    p        = XW'(pos);
    icmp_off = icmp_off_r;
    if (cfg.ip_version == IPV_V4 && pos == '0) begin
      icmp_off = {pkt_byte[3:0], 2'b00};
    end
    off   = (cfg.ip_version == IPV_V6) ? '0 : XW'(icmp_off);
    inner = inner_off_r;
    c0 = '0;
    c1 = '0;
    c2 = '0;
    c3 = '0;
    c4 = '0;
    if (cfg.probe_kind == KIND_ECHO) begin
      c0 = cmp_field(p, off, 3'd1,
                     (cfg.ip_version == IPV_V6) ? 32'(ICMP6_PING_REPLY) : 32'(ICMP4_ECHO_REPLY),
                     pkt_byte);
      c1 = cmp_field(p, off + XW'(4), 3'd2, 32'(cfg.echo_id), pkt_byte);
      c2 = cmp_field(p, off + XW'(6), 3'd2, 32'(cfg.ping_seq), pkt_byte);
      c3 = cmp_field(p, off + XW'(8), 3'd4, cfg.ping_cookie, pkt_byte);
      c4 = cmp_field(p, off + XW'(12), 3'd2, 32'(cfg.echo_port_tag), pkt_byte);
    end else if (cfg.ip_version == IPV_V4) begin
      c0 = cmp_field(p, off, 3'd1, 32'(ICMP4_DEST_UNREACH), pkt_byte);
      c1 = cmp_field(p, off + XW'(1), 3'd1, 32'(ICMP4_PORT_UNREACH), pkt_byte);
      // quoted IP header: its IHL places the inner UDP header
      if (p == off + XW'(8)) begin
        inner = 8'(icmp_off) + 8'd8 + {2'b00, pkt_byte[3:0], 2'b00};
      end
      c2 = cmp_field(p, off + XW'(17), 3'd1, 32'(IP_PROTO_UDP), pkt_byte);
      if (p >= off + XW'(8)) begin
        c3 = cmp_field(p, XW'(inner), 3'd2, 32'(cfg.local_port), pkt_byte);
        c4 = cmp_field(p, XW'(inner) + XW'(2), 3'd2, 32'(cfg.probe_port), pkt_byte);
      end
    end else begin
      c0 = cmp_field(p, '0, 3'd1, 32'(ICMP6_DEST_UNREACH), pkt_byte);
      c1 = cmp_field(p, XW'(1), 3'd1, 32'(ICMP6_PORT_UNREACH), pkt_byte);
      c2 = cmp_field(p, XW'(V6_NXT_HDR_POS), 3'd1, 32'(IP_PROTO_UDP), pkt_byte);
      c3 = cmp_field(p, XW'(V6_SRC_PORT_POS), 3'd2, 32'(cfg.local_port), pkt_byte);
      c4 = cmp_field(p, XW'(V6_DST_PORT_POS), 3'd2, 32'(cfg.probe_port), pkt_byte);
    end
    exam.hit_cnt   = 3'(c0[1]) + 3'(c1[1]) + 3'(c2[1]) + 3'(c3[1]) + 3'(c4[1]);
    exam.miss      = c0[0] | c1[0] | c2[0] | c3[0] | c4[0];
    exam.icmp_off  = icmp_off;
    exam.inner_off = inner;
  end

endmodule

// ===== rtl/iprm_pkt_state.sv =====
// Per-packet accumulation and end-of-packet verdict of the probe reply matcher.
module iprm_pkt_state import iprm_pkg::*; #(
  parameter int MAX_PKT_BYTES = MAX_PKT_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  step_t step,
  output res_t  res
);

  localparam int PW = $clog2(MAX_PKT_BYTES);
  localparam int CW = $clog2(MAX_PKT_BYTES + 1);

  localparam int MIN_LEN_ECHO_V4 = 28;
  localparam int MIN_LEN_ECHO_V6 = 8;
  localparam int MIN_LEN_UDP     = 56;
  localparam int REQ_ECHO        = 11;
  localparam int REQ_UDP         = 7;

  logic [CW-1:0] cnt_r,       cnt_nxt;
  logic [5:0]    icmp_off_r,  icmp_off_nxt;
  logic [7:0]    inner_off_r, inner_off_nxt;
  logic          miss_r,      miss_nxt;
  logic [4:0]    pass_r,      pass_nxt;
  exam_t         exam;

  iprm_examine #(.MAX_PKT_BYTES(MAX_PKT_BYTES)) u_examine (
    .cfg         (cfg),
    .pos         (cnt_r[PW-1:0]),
    .pkt_byte    (step.pkt_byte),
    .icmp_off_r  (icmp_off_r),
    .inner_off_r (inner_off_r),
    .exam        (exam)
  );

  always_comb begin
    logic [CW-1:0] min_len;
    logic [4:0]    req;
    logic          short_pkt;
    cnt_nxt       = cnt_r;
    icmp_off_nxt  = icmp_off_r;
    inner_off_nxt = inner_off_r;
    miss_nxt      = miss_r;
    pass_nxt      = pass_r;
    res           = '0;
    // bytes past the examined window only advance to the final byte
    if (step.go && cnt_r < CW'(MAX_PKT_BYTES)) begin
      cnt_nxt       = cnt_r + CW'(1);
      icmp_off_nxt  = exam.icmp_off;
      inner_off_nxt = exam.inner_off;
      miss_nxt      = miss_r | exam.miss;
      pass_nxt      = pass_r + 5'(exam.hit_cnt);
    end
    if (cfg.probe_kind == KIND_ECHO) begin
      min_len = (cfg.ip_version == IPV_V6) ? CW'(MIN_LEN_ECHO_V6) : CW'(MIN_LEN_ECHO_V4);
      req     = 5'(REQ_ECHO);
    end else begin
      min_len = CW'(MIN_LEN_UDP);
      req     = 5'(REQ_UDP);
    end
    short_pkt     = cnt_nxt < min_len;
    res.too_short = short_pkt;
    res.is_match  = !short_pkt && !miss_nxt && (pass_nxt == req);
    if (step.go && step.last) begin
      cnt_nxt       = '0;
      icmp_off_nxt  = '0;
      inner_off_nxt = '0;
      miss_nxt      = 1'b0;
      pass_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      icmp_off_r  <= '0;
      inner_off_r <= '0;
      miss_r      <= 1'b0;
      pass_r      <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      icmp_off_r  <= icmp_off_nxt;
      inner_off_r <= inner_off_nxt;
      miss_r      <= miss_nxt;
      pass_r      <= pass_nxt;
    end
  end

endmodule

// ===== rtl/icmp_probe_reply_matcher.sv =====
// Top level of the ICMP probe reply matcher: input stage, result register, assertions.
//
// Accepts one packet byte per cycle, back to back, and gives one verdict
// (is_match, too_short) per packet: out_valid rises at the clock edge after
// the one that accepts its final byte, provided the result register is free
// then. Each byte is registered, compared against the configured probe
// fields in one pass of logic and folded into the per-packet counters; the
// verdict is held in an output register. Input stall rises only while a final
// byte waits behind an earlier verdict that the result side has not yet taken.
// Only the first MAX_PKT_BYTES bytes of a packet are examined. The user must write
// configuration only while no packet is in flight; the block does not enforce it.
module icmp_probe_reply_matcher import iprm_pkg::*; #(
  parameter int MAX_PKT_BYTES = MAX_PKT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_pkt_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_match,
  output logic                  out_too_short,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  step_t      step;
  res_t       res;

  logic       s1_vld_r,  s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_res_r;

  logic       in_xfer;
  logic       out_free;
  logic       s1_go;

  iprm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iprm_pkt_state #(.MAX_PKT_BYTES(MAX_PKT_BYTES)) u_pkt_state (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .res   (res)
  );

  // a final byte may advance only if the result register is free this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign s1_go    = s1_vld_r && (!s1_last_r || out_free);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  assign step.go       = s1_go;
  assign step.last     = s1_last_r;
  assign step.pkt_byte = s1_byte_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_go && s1_last_r) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_pkt_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_go && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_is_match  = out_res_r.is_match;
  assign out_too_short = out_res_r.too_short;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s1_last_r && out_vld_r && out_stall))
    else $error("input stalled without a held verdict");

  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(s1_go && s1_last_r))
    else $error("verdict appeared without a final byte");

  a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_match && out_too_short))
    else $error("short packet reported as match");
`endif

endmodule

// ===== test/icmp_probe_reply_matcher_tb.sv =====
// Testbench for the ICMP probe reply matcher: random packets, byte-level predictor, verdict checks.
`timescale 1ns / 1ps

module icmp_probe_reply_matcher_tb import iprm_pkg::*;;

  localparam int ITEMS        = 1050;
  localparam int PHASE_BYTES  = 90;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int FRAME_ROOM   = 320;

  // Tracks one packet at a time and queues the verdict each final byte should produce.
  class verdict_board;
    cfg_t        regs;
    int          nbytes;
    logic [5:0]  icmp_off;
    logic [7:0]  udp_off;
    bit          miss;
    logic [4:0]  hits;
    res_t        want_verdicts[$];
    int          errors;
    int          taken;

    function new();
      regs = '0;
      errors = 0;
      taken = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      nbytes = 0;
      icmp_off = '0;
      udp_off = '0;
      miss = 1'b0;
      hits = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_IP_VERSION:    regs.ip_version = val[0];
        REG_PROBE_KIND:    regs.probe_kind = val[0];
        REG_ECHO_ID:       regs.echo_id = val[15:0];
        REG_PING_SEQ:      regs.ping_seq = val[15:0];
        REG_PING_COOKIE:   regs.ping_cookie = val;
        REG_ECHO_PORT_TAG: regs.echo_port_tag = val[15:0];
        REG_PROBE_PORT:    regs.probe_port = val[15:0];
        REG_LOCAL_PORT:    regs.local_port = val[15:0];
        default: ;
      endcase
    endfunction

    // Compare byte b at position p with byte p-base of a big-endian field of n bytes.
    function void cmp_field(int p, int base, int n, logic [31:0] want, logic [7:0] b);
      logic [31:0] shifted;
      if (p < base || p - base >= n) return;
      shifted = want >> (8 * (n - 1 - (p - base)));
      if (shifted[7:0] == b) hits = hits + 5'd1;
      else miss = 1'b1;
    endfunction

    function void examine(int p, logic [7:0] b);
      int off;
      if (regs.ip_version == IPV_V4 && p == 0) icmp_off = {b[3:0], 2'b00};
      off = (regs.ip_version == IPV_V6) ? 0 : int'(icmp_off);
      if (regs.probe_kind == KIND_ECHO) begin
        cmp_field(p, off, 1,
                  (regs.ip_version == IPV_V6) ? 32'(ICMP6_PING_REPLY) : 32'(ICMP4_ECHO_REPLY),
                  b);
        cmp_field(p, off + 4, 2, 32'(regs.echo_id), b);
        cmp_field(p, off + 6, 2, 32'(regs.ping_seq), b);
        cmp_field(p, off + 8, 4, regs.ping_cookie, b);
        cmp_field(p, off + 12, 2, 32'(regs.echo_port_tag), b);
      end else if (regs.ip_version == IPV_V4) begin
        cmp_field(p, off, 1, 32'(ICMP4_DEST_UNREACH), b);
        cmp_field(p, off + 1, 1, 32'(ICMP4_PORT_UNREACH), b);
        // quoted IP header length locates the quoted UDP header
        if (p == off + 8) udp_off = 8'(off + 8 + 4 * int'(b[3:0]));
        cmp_field(p, off + 17, 1, 32'(IP_PROTO_UDP), b);
        if (p >= off + 8) begin
          cmp_field(p, int'(udp_off), 2, 32'(regs.local_port), b);
          cmp_field(p, int'(udp_off) + 2, 2, 32'(regs.probe_port), b);
        end
      end else begin
        cmp_field(p, 0, 1, 32'(ICMP6_DEST_UNREACH), b);
        cmp_field(p, 1, 1, 32'(ICMP6_PORT_UNREACH), b);
        cmp_field(p, 14, 1, 32'(IP_PROTO_UDP), b);
        cmp_field(p, 48, 2, 32'(regs.local_port), b);
        cmp_field(p, 50, 2, 32'(regs.probe_port), b);
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int   min_len;
      int   required;
      res_t verdict;
      if (nbytes < MAX_PKT_BYTES_DEF) begin
        examine(nbytes, b);
        nbytes++;
      end
      if (!last) return;
      if (regs.probe_kind == KIND_ECHO) begin
        min_len = (regs.ip_version == IPV_V6) ? 8 : 28;
        required = 11;
      end else begin
        min_len = 56;
        required = 7;
      end
      verdict.too_short = (nbytes < min_len);
      verdict.is_match = !verdict.too_short && !miss && (int'(hits) == required);
      want_verdicts.push_back(verdict);
      clear_packet();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_verdict(logic got_match, logic got_short);
      res_t want;
      taken++;
      if (want_verdicts.size() == 0) begin
        flag($sformatf("verdict %0d unexpected: is_match=%0b too_short=%0b",
                       taken, got_match, got_short));
        return;
      end
      want = want_verdicts.pop_front();
      if (got_match !== want.is_match)
        flag($sformatf("verdict %0d is_match: expected %0b, got %0b",
                       taken, want.is_match, got_match));
      if (got_short !== want.too_short)
        flag($sformatf("verdict %0d too_short: expected %0b, got %0b",
                       taken, want.too_short, got_short));
    endfunction

    function int pending();
      return want_verdicts.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_pkt_byte;
  logic                  in_last_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_is_match;
  logic                  out_too_short;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  verdict_board sb;
  int           sent;
  bit           no_gap;
  bit           hold_long;
  logic [7:0]   frame[$];
  int           field_pos[$];

  always #10 clk = ~clk;

  icmp_probe_reply_matcher u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pkt_byte  (in_pkt_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_match (out_is_match),
    .out_too_short(out_too_short),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pkt_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, last);
    sent++;
  endtask

  // Drop valid and hold until every verdict is back and the pipe has emptied.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // style 0: all ones, 1: all zeros, 2: random
  task automatic configure(logic ipv, logic kind, int style);
    logic [31:0] v[6];
    int          i;
    for (i = 0; i < 6; i++)
      v[i] = (style == 0) ? '1 : (style == 1) ? '0 : $urandom;
    write_reg(REG_IP_VERSION, {31'd0, ipv});
    write_reg(REG_PROBE_KIND, {31'd0, kind});
    write_reg(REG_ECHO_ID, {16'd0, v[0][15:0]});
    write_reg(REG_PING_SEQ, {16'd0, v[1][15:0]});
    write_reg(REG_PING_COOKIE, v[2]);
    write_reg(REG_ECHO_PORT_TAG, {16'd0, v[3][15:0]});
    write_reg(REG_PROBE_PORT, {16'd0, v[4][15:0]});
    write_reg(REG_LOCAL_PORT, {16'd0, v[5][15:0]});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void put_field(int base, int n, logic [31:0] val);
    logic [31:0] shifted;
    int          i;
    for (i = 0; i < n; i++) begin
      shifted = val >> (8 * (n - 1 - i));
      frame[base + i] = shifted[7:0];
      field_pos.push_back(base + i);
    end
  endfunction

  // Build a reply that fits the current registers, then maybe break it, and send it.
  task automatic run_packet();
    int   ihl;
    int   ihl2;
    int   off;
    int   need;
    int   min_len;
    int   len;
    int   pick;
    int   pos;
    int   i;
    logic v6;
    logic udp;
    v6 = (sb.regs.ip_version == IPV_V6);
    udp = (sb.regs.probe_kind == KIND_UDP);
    frame.delete();
    field_pos.delete();
    for (i = 0; i < FRAME_ROOM; i++) frame.push_back(8'($urandom));
    pick = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
    ihl2 = $urandom_range(5, 15);
    off = v6 ? 0 : 4 * ihl;
    if (!v6) frame[0] = {4'h4, 4'(ihl)};
    if (!udp) begin
      put_field(off, 1, v6 ? 32'(ICMP6_PING_REPLY) : 32'(ICMP4_ECHO_REPLY));
      put_field(off + 4, 2, 32'(sb.regs.echo_id));
      put_field(off + 6, 2, 32'(sb.regs.ping_seq));
      put_field(off + 8, 4, sb.regs.ping_cookie);
      put_field(off + 12, 2, 32'(sb.regs.echo_port_tag));
      need = off + 14;
      min_len = v6 ? 8 : 28;
    end else if (!v6) begin
      put_field(off, 1, 32'(ICMP4_DEST_UNREACH));
      put_field(off + 1, 1, 32'(ICMP4_PORT_UNREACH));
      put_field(off + 8, 1, {24'd0, 4'h4, 4'(ihl2)});
      put_field(off + 17, 1, 32'(IP_PROTO_UDP));
      put_field(off + 8 + 4 * ihl2, 2, 32'(sb.regs.local_port));
      put_field(off + 10 + 4 * ihl2, 2, 32'(sb.regs.probe_port));
      need = off + 12 + 4 * ihl2;
      min_len = 56;
    end else begin
      put_field(0, 1, 32'(ICMP6_DEST_UNREACH));
      put_field(1, 1, 32'(ICMP6_PORT_UNREACH));
      put_field(14, 1, 32'(IP_PROTO_UDP));
      put_field(48, 2, 32'(sb.regs.local_port));
      put_field(50, 2, 32'(sb.regs.probe_port));
      need = 52;
      min_len = 56;
    end
    len = ((need > min_len) ? need : min_len) + $urandom_range(0, 6);
    if (pick < 10) begin
      pos = field_pos[$urandom_range(0, field_pos.size() - 1)];
      frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
    end else if (pick < 20) begin
      len = $urandom_range(1, len - 1);
    end else if (pick < 24) begin
      len = $urandom_range(MAX_PKT_BYTES_DEF + 1, FRAME_ROOM - 20);
    end else if (pick < 32) begin
      for (i = 0; i < FRAME_ROOM; i++) frame[i] = 8'($urandom);
      len = $urandom_range(1, 72);
    end
    no_gap = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) push_byte(frame[i], i == len - 1);
    no_gap = 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    int phase_start;
    sb = new();
    sent = 0;
    no_gap = 1'b0;
    hold_long = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pkt_byte = '0;
    in_last_byte = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte packets under the reset registers: both too short
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    settle();
    // IPv6 echo cut off two bytes into the cookie: long enough, but never a match
    configure(IPV_V6, KIND_ECHO, 0);
    push_byte(ICMP6_PING_REPLY, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    phase = 0;
    while (sent < ITEMS) begin
      configure(phase[0], phase[1], phase % 3);
      if (phase == 1) begin
        // back up verdicts behind a long result-side hold so input stall rises
        hold_long = 1'b1;
        repeat (12) push_byte(8'($urandom), 1'b1);
      end
      phase_start = sent;
      while (sent - phase_start < PHASE_BYTES) run_packet();
      settle();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_sink
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        hold = no_gap ? 0 : $urandom_range(0, 6);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_verdict(out_is_match, out_too_short);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iprm_pkg.sv
rtl/iprm_cfg_regs.sv
rtl/iprm_examine.sv
rtl/iprm_pkt_state.sv
rtl/icmp_probe_reply_matcher.sv
test/icmp_probe_reply_matcher_tb.sv
